// File: src/pdpp_pkg.sv
// shared types, constants and pattern rom for the duty pattern player
package pdpp_pkg;

	localparam int NUM_EFFECTS = 11;
	localparam int MAX_STEPS   = 10;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_PLAY = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	typedef struct packed {
		logic [3:0] active_effect;
		logic [3:0] step_index;
		logic [7:0] elapsed_ms;
		logic [7:0] duty_level;
	} pdpp_state_t;

	typedef logic [7:0] rom_row_t [MAX_STEPS];

	localparam rom_row_t ROM_DUTY [NUM_EFFECTS] = '{
		'{8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd180, 8'd0, 8'd180, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd220, 8'd0, 8'd160, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd255, 8'd200, 8'd150, 8'd100, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd100, 8'd0, 8'd180, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd150, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd120, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd200, 8'd0, 8'd200, 8'd0, 8'd200, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0},
		'{8'd255, 8'd200, 8'd150, 8'd100, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd150, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
	};

	localparam rom_row_t ROM_MS [NUM_EFFECTS] = '{
		'{8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd20, 8'd20, 8'd20, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd25, 8'd15, 8'd25, 8'd15, 8'd25, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd30, 8'd10, 8'd30, 8'd10, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd80, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd15, 8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd40, 8'd30, 8'd40, 8'd30, 8'd40, 8'd30, 8'd40, 8'd30, 8'd60, 8'd0},
		'{8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd200, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
	};

	// effect numbers start at 1; anything out of range reads as zero
	function automatic logic [7:0] rom_duty(input logic [3:0] fx, input logic [3:0] st);
		logic [7:0] val;
		val = 8'd0;
		if (fx != 4'd0 && fx <= 4'(NUM_EFFECTS) && st < 4'(MAX_STEPS)) begin
			val = ROM_DUTY[fx - 4'd1][st];
		end
		return val;
	endfunction

	function automatic logic [7:0] rom_ms(input logic [3:0] fx, input logic [3:0] st);
		logic [7:0] val;
		val = 8'd0;
		if (fx != 4'd0 && fx <= 4'(NUM_EFFECTS) && st < 4'(MAX_STEPS)) begin
			val = ROM_MS[fx - 4'd1][st];
		end
		return val;
	endfunction

endpackage

// File: src/pdpp_req_if.sv
// request channel: command and effect number
interface pdpp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [3:0] effect;

	modport source (output valid, command, effect, input ready);
	modport sink   (input valid, command, effect, output ready);
endinterface

// File: src/pdpp_rsp_if.sv
// result channel: duty, busy flag and playing effect
interface pdpp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty;
	logic       busy_res;
	logic [3:0] playing;

	modport source  (output valid, duty, busy_res, playing, input ready);
	modport sink    (input valid, duty, busy_res, playing, output ready);
	modport monitor (input valid, ready, duty, busy_res, playing);
endinterface

// File: src/pdpp_core.sv
// player state registers and the per-item next-state logic
module pdpp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [1:0]           command,
	input  logic [3:0]           effect,
	output pdpp_pkg::pdpp_state_t nxt
);

	pdpp_pkg::pdpp_state_t state_q;
	pdpp_pkg::pdpp_state_t idle_st;
	logic [7:0] elapsed_inc;
	logic [3:0] step_next;
	logic [7:0] ms_cur;
	logic [7:0] ms_next;

	assign idle_st     = '0;
	assign elapsed_inc = (state_q.elapsed_ms != 8'hFF) ? state_q.elapsed_ms + 8'd1
	                                                   : state_q.elapsed_ms;
	assign step_next   = state_q.step_index + 4'd1;
	assign ms_cur      = pdpp_pkg::rom_ms(state_q.active_effect, state_q.step_index);
	assign ms_next     = pdpp_pkg::rom_ms(state_q.active_effect, step_next);

	always_comb begin
		nxt = state_q;
		unique case (command)
			pdpp_pkg::CMD_TICK: begin
				if (state_q.active_effect == 4'd0
				    || state_q.active_effect > 4'(pdpp_pkg::NUM_EFFECTS)
				    || state_q.step_index >= 4'(pdpp_pkg::MAX_STEPS)) begin
					nxt = idle_st;
				end else if (elapsed_inc < ms_cur) begin
					nxt.elapsed_ms = elapsed_inc;
				end else if (step_next >= 4'(pdpp_pkg::MAX_STEPS) || ms_next == 8'd0) begin
					nxt = idle_st;
				end else begin
					nxt.step_index = step_next;
					nxt.elapsed_ms = 8'd0;
					nxt.duty_level = pdpp_pkg::rom_duty(state_q.active_effect, step_next);
				end
			end
			pdpp_pkg::CMD_PLAY: begin
				// lower number wins, equal number restarts
				if (effect != 4'd0 && effect <= 4'(pdpp_pkg::NUM_EFFECTS)
				    && (state_q.active_effect == 4'd0 || effect <= state_q.active_effect)) begin
					nxt.active_effect = effect;
					nxt.step_index    = 4'd0;
					nxt.elapsed_ms    = 8'd0;
					nxt.duty_level    = pdpp_pkg::rom_duty(effect, 4'd0);
				end
			end
			pdpp_pkg::CMD_STOP: begin
				nxt = idle_st;
			end
			default: begin
				nxt = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (en) begin
			state_q <= nxt;
		end
	end

endmodule

// File: src/priority_duty_pattern_player_unit.sv
// top level of the priority duty pattern player
//
//  channel | dir | fields                      | handshake
//  --------+-----+-----------------------------+-------------
//  req     | in  | command[1:0], effect[3:0]   | valid/ready
//  rsp     | out | duty[7:0], busy_res, playing| valid/ready
//
// one item per cycle sustained while rsp.ready stays high; a request passes
// the input register, then the state update into the result register
// reset clears the player state and both stage valid flags, no warm-up
// a stalled result holds stage 2; stage 1 then holds, and req.ready
// drops only when both stages are full and rsp.ready is low
module priority_duty_pattern_player_unit (
	input  logic          clk,
	input  logic          arst_n,
	pdpp_req_if.sink      req,
	pdpp_rsp_if.source    rsp
);

	// stage 1: registered request item
	logic       valid_s1;
	logic [1:0] command_s1;
	logic [3:0] effect_s1;

	// stage 2: result item, the player state after the item
	logic       valid_s2;
	logic [7:0] duty_s2;
	logic [3:0] playing_s2;

	logic adv_s1;
	logic load_s1;
	pdpp_pkg::pdpp_state_t nxt;

	// stage 1 moves on when the result slot is free or being emptied
	assign adv_s1    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1 <= req.command;
			effect_s1  <= req.effect;
		end
	end

	// state only advances when the item really moves into the result stage
	pdpp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && adv_s1),
		.command (command_s1),
		.effect  (effect_s1),
		.nxt     (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			duty_s2    <= nxt.duty_level;
			playing_s2 <= nxt.active_effect;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.duty     = duty_s2;
	assign rsp.playing  = playing_s2;
	assign rsp.busy_res = (playing_s2 != 4'd0);

endmodule

// File: src/pdpp_chk.sv
// port-level checks for the duty pattern player, bound to the top level
module pdpp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] duty,
	input logic       busy_res,
	input logic [3:0] playing
);

	// busy flag follows the playing number
	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (busy_res == (playing != 4'd0)))
		else $error("busy_res disagrees with playing");

	// idle means silent
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !busy_res) |-> (duty == 8'd0))
		else $error("duty nonzero while idle");

	// only effects from the rom can be playing
	a_playing_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (playing <= 4'(pdpp_pkg::NUM_EFFECTS)))
		else $error("playing effect out of range");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ready) |=> (valid && $stable(duty) && $stable(playing)))
		else $error("result changed while stalled");

endmodule

bind priority_duty_pattern_player_unit pdpp_chk u_pdpp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (rsp.valid),
	.ready    (rsp.ready),
	.duty     (rsp.duty),
	.busy_res (rsp.busy_res),
	.playing  (rsp.playing)
);

// File: tb/tb_top.sv
// testbench for the duty pattern player: item-level predictor with random stalls on both channels
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// command code that the player leaves alone
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// generous bound: about 1900 items, each with worst-case gaps on both sides
	localparam int CYCLE_LIMIT = 1_000_000;

	// pattern tables, one row per effect (effect 1 first), zero duration ends a row
	localparam int PAT_DUTY [pdpp_pkg::NUM_EFFECTS][pdpp_pkg::MAX_STEPS] = '{
		'{200, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{180, 0, 180, 0, 0, 0, 0, 0, 0, 0},
		'{220, 0, 160, 0, 100, 0, 0, 0, 0, 0},
		'{255, 200, 150, 100, 50, 0, 0, 0, 0, 0},
		'{100, 0, 180, 0, 255, 0, 0, 0, 0, 0},
		'{150, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{120, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{200, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{200, 0, 200, 0, 200, 0, 255, 0, 255, 0},
		'{255, 200, 150, 100, 50, 0, 0, 0, 0, 0},
		'{150, 0, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	localparam int PAT_MS [pdpp_pkg::NUM_EFFECTS][pdpp_pkg::MAX_STEPS] = '{
		'{30, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{20, 20, 20, 0, 0, 0, 0, 0, 0, 0},
		'{25, 15, 25, 15, 25, 0, 0, 0, 0, 0},
		'{100, 100, 100, 100, 100, 0, 0, 0, 0, 0},
		'{30, 10, 30, 10, 30, 0, 0, 0, 0, 0},
		'{80, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{15, 15, 0, 0, 0, 0, 0, 0, 0, 0},
		'{15, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{40, 30, 40, 30, 40, 30, 40, 30, 60, 0},
		'{200, 200, 200, 200, 200, 0, 0, 0, 0, 0},
		'{200, 200, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	// what the result channel should show after one item
	typedef struct {
		logic [7:0] duty;
		logic       busy;
		logic [3:0] playing;
	} buzzer_view_t;

	logic clk = 1'b0;
	logic arst_n;

	pdpp_req_if req ();
	pdpp_rsp_if rsp ();

	priority_duty_pattern_player_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #2 clk = ~clk;

	// predicted player state and the views still waiting on the result channel
	pdpp_pkg::pdpp_state_t player_st;
	buzzer_view_t          pending_views [$];

	// gaps on both channels are switched on and off per phase
	bit idle_on;
	int stall_left;

	int errors;
	int cycle_count;
	int sent_items;
	int checked_results;
	int n_ticks, n_plays, n_stops, n_unused, n_ignored_plays, n_patterns_done;

	// mostly back to back, sometimes a few cycles, now and then a long gap
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// apply one accepted item to the predicted state and queue the view it leaves
	task automatic update_player(input logic [1:0] cmd, input logic [3:0] fx);
		int row;
		int nxt;
		buzzer_view_t view;
		case (cmd)
			pdpp_pkg::CMD_TICK: begin
				n_ticks++;
				if (player_st.active_effect == 4'd0
						|| player_st.active_effect > 4'(pdpp_pkg::NUM_EFFECTS)
						|| player_st.step_index >= 4'(pdpp_pkg::MAX_STEPS)) begin
					// idle tick (or a state that cannot play): nothing to advance
					player_st = '0;
				end else begin
					row = int'(player_st.active_effect) - 1;
					// elapsed count saturates rather than wrapping
					if (player_st.elapsed_ms != 8'd255) begin
						player_st.elapsed_ms = player_st.elapsed_ms + 8'd1;
					end
					if (int'(player_st.elapsed_ms) >= PAT_MS[row][player_st.step_index]) begin
						nxt = int'(player_st.step_index) + 1;
						if (nxt >= pdpp_pkg::MAX_STEPS || PAT_MS[row][nxt] == 0) begin
							// terminator reached (or table end): go silent
							player_st = '0;
							n_patterns_done++;
						end else begin
							player_st.step_index = 4'(nxt);
							player_st.elapsed_ms = 8'd0;
							player_st.duty_level = 8'(PAT_DUTY[row][nxt]);
						end
					end
				end
			end
			pdpp_pkg::CMD_PLAY: begin
				n_plays++;
				// out of range or lower priority than what plays: ignored
				if (fx == 4'd0 || fx > 4'(pdpp_pkg::NUM_EFFECTS)
						|| (player_st.active_effect != 4'd0 && fx > player_st.active_effect)) begin
					n_ignored_plays++;
				end else begin
					player_st.active_effect = fx;
					player_st.step_index = 4'd0;
					player_st.elapsed_ms = 8'd0;
					player_st.duty_level = 8'(PAT_DUTY[int'(fx) - 1][0]);
				end
			end
			pdpp_pkg::CMD_STOP: begin
				n_stops++;
				player_st = '0;
			end
			default: begin
				n_unused++;
			end
		endcase
		view.duty = player_st.duty_level;
		view.busy = (player_st.active_effect != 4'd0);
		view.playing = player_st.active_effect;
		pending_views.push_back(view);
	endtask

	// present one item, hold it until accepted, then predict its result
	task automatic send_item(input logic [1:0] cmd, input logic [3:0] fx);
		int g;
		g = idle_on ? gap_len() : 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.effect <= fx;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		update_player(cmd, fx);
		sent_items++;
	endtask

	// hold the sender off until every predicted result has come back
	task automatic drain_results();
		req.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_views.size() != 0);
	endtask

	// reset state, every command, out-of-range and lower-priority plays, restart, takeover
	task automatic test_corner_items();
		send_item(pdpp_pkg::CMD_TICK, 4'd15);   // tick while idle, effect field set
		send_item(CMD_UNUSED, 4'd10);           // unused command while idle
		send_item(pdpp_pkg::CMD_STOP, 4'd0);    // stop while idle
		send_item(pdpp_pkg::CMD_PLAY, 4'd0);    // effect zero is ignored
		send_item(pdpp_pkg::CMD_PLAY, 4'd12);   // just above the last effect
		send_item(pdpp_pkg::CMD_PLAY, 4'd15);   // all effect bits high
		send_item(pdpp_pkg::CMD_PLAY, 4'd11);   // lowest priority effect starts from idle
		send_item(pdpp_pkg::CMD_PLAY, 4'd12);   // out of range while playing
		send_item(pdpp_pkg::CMD_PLAY, 4'd6);    // higher priority takes over
		send_item(pdpp_pkg::CMD_PLAY, 4'd7);    // lower priority ignored
		send_item(pdpp_pkg::CMD_PLAY, 4'd6);    // same effect restarts
		send_item(pdpp_pkg::CMD_TICK, 4'd0);
		send_item(CMD_UNUSED, 4'd5);            // unused command while playing
		send_item(pdpp_pkg::CMD_PLAY, 4'd1);    // top priority takes over
		send_item(pdpp_pkg::CMD_STOP, 4'd3);    // stop with effect field set
		send_item(pdpp_pkg::CMD_PLAY, 4'd8);
		repeat (3) send_item(pdpp_pkg::CMD_TICK, 4'd9);
		send_item(pdpp_pkg::CMD_PLAY, 4'd8);    // restart mid-step clears the elapsed count
		send_item(pdpp_pkg::CMD_STOP, 4'd15);
	endtask

	// play an effect and tick through it, mostly to the end, with the odd interruption
	task automatic test_full_patterns(input int budget);
		int stop_at;
		int fx;
		int len;
		int n;
		int r;
		stop_at = sent_items + budget;
		while (sent_items < stop_at) begin
			fx = $urandom_range(1, pdpp_pkg::NUM_EFFECTS);
			len = 0;
			for (int s = 0; s < pdpp_pkg::MAX_STEPS && PAT_MS[fx - 1][s] != 0; s++) begin
				len += PAT_MS[fx - 1][s];
			end
			// short patterns run to their end or past it; long ones up to 500 only now and then
			if (len <= 120 || ($urandom_range(0, 5) == 0 && len <= 500)) begin
				n = len + $urandom_range(0, 3);
			end else begin
				n = $urandom_range(1, (len > 450) ? 450 : len);
			end
			send_item(pdpp_pkg::CMD_PLAY, 4'(fx));
			for (int k = 0; k < n && sent_items < stop_at; k++) begin
				r = $urandom_range(0, 59);
				case (r)
					0: send_item(pdpp_pkg::CMD_PLAY, 4'($urandom_range(0, 15)));
					1: send_item(pdpp_pkg::CMD_PLAY, player_st.active_effect);
					2: send_item(pdpp_pkg::CMD_STOP, 4'($urandom_range(0, 15)));
					3: send_item(CMD_UNUSED, 4'($urandom_range(0, 15)));
					default: send_item(pdpp_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
				endcase
			end
			if ($urandom_range(0, 4) == 0) begin
				drain_results();
			end
		end
	endtask

	// unstructured items over the full range of both fields
	task automatic test_mixed_noise(input int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_item(pdpp_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
			end else if (r < 75) begin
				send_item(pdpp_pkg::CMD_PLAY, 4'($urandom_range(0, 15)));
			end else if (r < 90) begin
				send_item(pdpp_pkg::CMD_STOP, 4'($urandom_range(0, 15)));
			end else begin
				send_item(CMD_UNUSED, 4'($urandom_range(0, 15)));
			end
		end
	endtask

	// result side: random back-pressure while the phase allows it
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (idle_on && arst_n) begin : pick_stall
			int g;
			g = gap_len();
			rsp.ready <= (g == 0);
			if (g > 0) begin
				stall_left <= g - 1;
			end
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin : check_result
			buzzer_view_t want;
			if (pending_views.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: duty %0d busy %0b playing %0d",
					rsp.duty, rsp.busy_res, rsp.playing));
			end else begin
				want = pending_views.pop_front();
				checked_results++;
				if (rsp.duty !== want.duty) begin
					report_mismatch($sformatf("duty %0d, expected %0d", rsp.duty, want.duty));
				end
				if (rsp.busy_res !== want.busy) begin
					report_mismatch($sformatf("busy_res %0b, expected %0b", rsp.busy_res, want.busy));
				end
				if (rsp.playing !== want.playing) begin
					report_mismatch($sformatf("playing %0d, expected %0d", rsp.playing, want.playing));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_views.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = pdpp_pkg::CMD_TICK;
		req.effect = 4'd0;
		rsp.ready = 1'b0;
		player_st = '0;
		idle_on = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		test_corner_items();
		drain_results();

		// one stretch back to back on both sides, then with gaps
		idle_on = 1'b0;
		test_full_patterns(700);
		drain_results();
		idle_on = 1'b1;
		test_full_patterns(700);
		drain_results();
		test_mixed_noise(450);

		// let the pipeline settle; stray results would show up here
		drain_results();
		repeat (10) @(posedge clk);

		$display("run covered %0d items: %0d ticks, %0d plays (%0d ignored), %0d stops, %0d unused",
			sent_items, n_ticks, n_plays, n_ignored_plays, n_stops, n_unused);
		$display("%0d results checked, %0d patterns played through to silence",
			checked_results, n_patterns_done);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
